### hdl/keyword_substitution_cipher_core_defines.svh
// Assertion macros for the checker file of the cipher core.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_CORE_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define KSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cipher core check failed");

// Next-cycle implication, disabled while reset is held.
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cipher core check failed");

`endif

### hdl/ksc_pkg.sv
// Shared types, constants and the letter decoder of the cipher core.
package ksc_pkg;

    localparam int LETTERS = 26;

    localparam logic [7:0] LOWER_A      = 8'd97;
    localparam logic [7:0] CASE_GAP     = 8'd32;
    localparam logic [7:0] SPACE_CHAR   = 8'd32;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [4:0] LAST_LETTER = 5'(LETTERS - 1);
    localparam logic [4:0] FULL_COUNT  = 5'(LETTERS);

    typedef logic [4:0] t_letter;

    typedef enum logic [2:0] {
        MODE_KEY_BEGIN  = 3'd0,
        MODE_KEY_CHAR   = 3'd1,
        MODE_KEY_FINISH = 3'd2,
        MODE_ENCRYPT    = 3'd3,
        MODE_DECRYPT    = 3'd4
    } t_mode;

    // Control word from the sequencer to the table store
    typedef struct packed {
        logic    clear;
        logic    place_en;
        t_letter place_letter;
    } t_tbl_ctrl;

    typedef struct packed {
        logic    valid;
        t_letter idx;
    } t_letter_dec;

    // Fold case and map a byte to a letter index
    function automatic t_letter_dec letter_index(input logic [7:0] c);
        logic [7:0]  v;
        t_letter_dec d;
        v = c;
        if (v >= CHAR_UPPER_A && v <= CHAR_UPPER_Z) begin
            v = v + CASE_GAP;
        end
        d.valid = (v >= CHAR_LOWER_A && v <= CHAR_LOWER_Z);
        d.idx   = 5'(v - CHAR_LOWER_A);
        return d;
    endfunction

endpackage

### hdl/keyword_substitution_cipher_core.sv
// Keyword substitution cipher core: one character word in, at most one word out.
// Usage: each input word carries a mode in tuser and a character in tdata. Key
// begin, key character, encrypt and decrypt words can be sent back to back
// while the output is not stalled; encrypt and decrypt give a lowercase letter
// or a space on the output register in the next cycle, and drop other
// characters. Key finish is accepted and then followed by 26 steps of the
// placement unit, which walks the alphabet one letter a cycle and assigns every
// unused letter in order; tready stays low during that walk. Tables come out of
// reset as the identity mapping. The output register parts the two sides: a new
// word is taken when the output is empty or being drained in the same cycle.
module keyword_substitution_cipher_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    input  logic [2:0] i_s_tuser,   // [2:0] mode
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [7:0] char_out
);
    import ksc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state      r_state, n_state;
    t_letter     r_walk,  n_walk;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_odata,  n_odata;

    logic        accept;
    t_mode       mode;
    t_letter_dec dec;
    t_tbl_ctrl   ctrl;
    t_letter     fwd, inv;

    assign mode   = t_mode'(i_s_tuser);
    assign dec    = letter_index(i_s_tdata);
    assign o_s_tready = (r_state == ST_IDLE) && (!r_ovalid || i_m_tready);
    assign accept = i_s_tvalid && o_s_tready;

    ksc_tables u_tables (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_rd_letter (dec.idx),
        .o_fwd       (fwd),
        .o_inv       (inv)
    );

    // Sequence modes and drive the table store
    always_comb begin
        n_state       = r_state;
        n_walk        = r_walk;
        n_ovalid      = r_ovalid && !i_m_tready;
        n_odata       = r_odata;
        ctrl.clear    = 1'b0;
        ctrl.place_en = 1'b0;
        ctrl.place_letter = dec.idx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_KEY_BEGIN: ctrl.clear = 1'b1;
                        MODE_KEY_CHAR:  ctrl.place_en = dec.valid;
                        MODE_KEY_FINISH: begin
                            n_walk  = '0;
                            n_state = ST_WALK;
                        end
                        MODE_ENCRYPT, MODE_DECRYPT: begin
                            if (i_s_tdata == SPACE_CHAR) begin
                                n_ovalid = 1'b1;
                                n_odata  = SPACE_CHAR;
                            end else if (dec.valid) begin
                                n_ovalid = 1'b1;
                                n_odata  = LOWER_A + {3'b000,
                                           (mode == MODE_ENCRYPT) ? fwd : inv};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                ctrl.place_en     = 1'b1;
                ctrl.place_letter = r_walk;
                n_walk            = r_walk + 5'd1;
                if (r_walk == LAST_LETTER) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_walk   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_walk   <= n_walk;
            r_ovalid <= n_ovalid;
        end
    end

    // Hold the output word
    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

### hdl/ksc_tables.sv
// Forward and inverse letter tables with the shared letter placement unit.
module ksc_tables (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ksc_pkg::t_tbl_ctrl i_ctrl,
    input  ksc_pkg::t_letter   i_rd_letter,
    output ksc_pkg::t_letter   o_fwd,
    output ksc_pkg::t_letter   o_inv
);
    import ksc_pkg::*;

    t_letter             r_fwd [LETTERS];
    t_letter             r_inv [LETTERS];
    logic [LETTERS-1:0]  r_used;
    logic [4:0]          r_fill;
    logic                place_ok;

    // Place only a fresh letter while slots remain
    assign place_ok = i_ctrl.place_en && (r_fill < FULL_COUNT)
                      && (i_ctrl.place_letter <= LAST_LETTER)
                      && !r_used[i_ctrl.place_letter];

    // Clear to identity, or write one letter into both tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int i = 0; i < LETTERS; i++) begin
                r_fwd[i] <= 5'(i);
                r_inv[i] <= 5'(i);
            end
            r_used <= '0;
            r_fill <= '0;
        end else if (place_ok) begin
            r_fwd[r_fill]              <= i_ctrl.place_letter;
            r_inv[i_ctrl.place_letter] <= r_fill;
            r_used[i_ctrl.place_letter] <= 1'b1;
            r_fill                     <= r_fill + 5'd1;
        end
    end

    // Look up the text letter in both directions
    assign o_fwd = r_fwd[i_rd_letter];
    assign o_inv = r_inv[i_rd_letter];

endmodule

### hdl/keyword_substitution_cipher_core_checker.sv
// Port-level checker for the cipher core, bound to the top level.
`include "keyword_substitution_cipher_core_defines.svh"

module keyword_substitution_cipher_core_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [2:0] i_s_tuser,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);
    import ksc_pkg::*;

    logic s_acc;
    logic finish_acc;
    logic out_legal;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign finish_acc = s_acc && (i_s_tuser == MODE_KEY_FINISH);
    assign out_legal  = (o_m_tdata == SPACE_CHAR)
                        || ((o_m_tdata >= CHAR_LOWER_A) && (o_m_tdata <= CHAR_LOWER_Z));

    // A stalled output word stays offered
    `KSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // Key finish blocks the input while the alphabet is walked
    `KSC_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n, finish_acc, !o_s_tready)

    // A new output word follows an accepted input word
    `KSC_ASSERT_NOW(a_out_cause, i_clk, i_rst_n, $rose(o_m_tvalid), $past(s_acc))

    // Output is a lowercase letter or a space
    `KSC_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_m_tvalid, out_legal)

endmodule

bind keyword_substitution_cipher_core keyword_substitution_cipher_core_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
